### rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and codes for the soft timer bank: command and response
// beats, operation and mode codes, signal groups between controller and datapath.
// ----------------------------------------------------------------------------
package stb_pkg;

	typedef logic [2:0] op_t;
	typedef logic [1:0] mode_t;

	localparam op_t OP_TICK     = 3'd0;
	localparam op_t OP_REGISTER = 3'd1;
	localparam op_t OP_CHANGE   = 3'd2;
	localparam op_t OP_CHECK    = 3'd3;
	localparam op_t OP_POLL     = 3'd4;

	localparam mode_t MODE_ONCE    = 2'd0;
	localparam mode_t MODE_AUTO    = 2'd1;
	localparam mode_t MODE_FOREVER = 2'd2;

	localparam int TICKS_W = 32;
	localparam int INDEX_W = 3;
	// wide enough to compare an index against a bank size of up to 127
	localparam int CMP_W   = 7;

	typedef struct packed {
		op_t                op;
		logic [INDEX_W-1:0] timer_index;
		mode_t              mode;
		logic [TICKS_W-1:0] ticks;
	} cmd_t;

	typedef struct packed {
		logic due;
		logic status;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic walk_rd;
	} ctl_t;

	typedef struct packed {
		logic walk_last;
	} stat_t;

endpackage

### rtl/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb_ctrl
// Sequencer for the timer bank: takes command beats, runs the tick walk over
// all timers and raises the response strobe.
// ----------------------------------------------------------------------------
module stb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  stb_pkg::op_t   op,
	input  stb_pkg::stat_t stat,
	output stb_pkg::ctl_t  ctl,
	output logic           busy,
	output logic           done
);
	import stb_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (op == OP_TICK) begin
							state_q <= S_WALK;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_WALK: begin
					if (stat.walk_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last timer is written back this cycle
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign ctl.accept  = start && (state_q == S_IDLE);
	assign ctl.walk_rd = (state_q == S_WALK);
	assign done        = done_q;

endmodule

### rtl/stb_datapath.sv
// ----------------------------------------------------------------------------
// stb_datapath
// Timer storage and the shared decrementer. Counts and reload values sit in
// memories; registered, due and mode bits sit in flops per timer.
// ----------------------------------------------------------------------------
module stb_datapath #(
	parameter int NUM_TIMERS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  stb_pkg::ctl_t  ctl,
	input  stb_pkg::cmd_t  cmd,
	output stb_pkg::stat_t stat,
	output stb_pkg::rsp_t  rsp
);
	import stb_pkg::*;

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [TICKS_W-1:0] remaining_mem [NUM_TIMERS];
	logic [TICKS_W-1:0] reload_mem    [NUM_TIMERS];

	logic [NUM_TIMERS-1:0] registered_q;
	logic [NUM_TIMERS-1:0] due_q;
	logic [NUM_TIMERS-1:0] auto_q;
	logic [NUM_TIMERS-1:0] forever_q;

	logic [AW-1:0]      cnt_q;
	logic               valid_s1;
	logic [AW-1:0]      addr_s1;
	logic [TICKS_W-1:0] rem_s1;
	logic [TICKS_W-1:0] rel_s1;
	rsp_t               rsp_q;

	logic [CMP_W-1:0]   idx_w;
	logic               in_bank;
	logic [AW-1:0]      addr;
	logic               reg_hit;
	logic               is_reg;
	logic               is_change;
	logic               is_check;
	logic               is_poll;
	rsp_t               rsp_d;

	logic               dec_en;
	logic               hit_zero;
	logic [TICKS_W-1:0] dec_val;
	logic [TICKS_W-1:0] wb_val;

	// command decode
	always_comb begin
		idx_w     = CMP_W'(cmd.timer_index);
		in_bank   = idx_w < CMP_W'(NUM_TIMERS);
		addr      = AW'(idx_w);
		reg_hit   = in_bank && registered_q[addr];
		is_reg    = 1'b0;
		is_change = 1'b0;
		is_check  = 1'b0;
		is_poll   = 1'b0;
		unique case (cmd.op)
			OP_REGISTER: is_reg    = 1'b1;
			OP_CHANGE:   is_change = 1'b1;
			OP_CHECK:    is_check  = 1'b1;
			OP_POLL:     is_poll   = 1'b1;
			default:     ;
		endcase
		rsp_d.due    = (is_check || is_poll) && reg_hit && due_q[addr];
		rsp_d.status = (is_reg && !in_bank)
			|| ((is_change || is_check || is_poll) && !reg_hit);
	end

	// shared decrementer on the walk stage
	always_comb begin
		dec_en   = valid_s1 && registered_q[addr_s1] && (rem_s1 != '0);
		hit_zero = (rem_s1 == TICKS_W'(1));
		dec_val  = rem_s1 - TICKS_W'(1);
		wb_val   = (hit_zero && auto_q[addr_s1]) ? rel_s1 : dec_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			registered_q <= '0;
			due_q        <= '0;
			auto_q       <= '0;
			forever_q    <= '0;
			cnt_q        <= '0;
			valid_s1     <= 1'b0;
			rsp_q        <= '0;
		end else begin
			valid_s1 <= ctl.walk_rd;
			if (ctl.accept) begin
				cnt_q <= '0;
				rsp_q <= rsp_d;
				if (is_reg && in_bank) begin
					registered_q[addr] <= 1'b1;
					due_q[addr]        <= 1'b0;
					auto_q[addr]       <= (cmd.mode == MODE_AUTO);
					forever_q[addr]    <= (cmd.mode == MODE_FOREVER);
				end
				if (is_change && reg_hit) begin
					auto_q[addr]    <= (cmd.mode == MODE_AUTO);
					forever_q[addr] <= (cmd.mode == MODE_FOREVER);
				end
				if ((is_check || (is_poll && !forever_q[addr])) && reg_hit) begin
					due_q[addr] <= 1'b0;
				end
			end else if (ctl.walk_rd) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (dec_en && hit_zero) begin
				due_q[addr_s1] <= 1'b1;
			end
		end
	end

	// count and reload memories
	always_ff @(posedge clk) begin
		if (ctl.accept && is_reg && in_bank) begin
			remaining_mem[addr] <= cmd.ticks;
			reload_mem[addr]    <= cmd.ticks;
		end else if (ctl.accept && is_change && reg_hit) begin
			reload_mem[addr] <= cmd.ticks;
		end
		if (dec_en) begin
			remaining_mem[addr_s1] <= wb_val;
		end
		if (ctl.walk_rd) begin
			rem_s1  <= remaining_mem[cnt_q];
			rel_s1  <= reload_mem[cnt_q];
			addr_s1 <= cnt_q;
		end
	end

	assign stat.walk_last = (cnt_q == AW'(NUM_TIMERS - 1));
	assign rsp            = rsp_q;

endmodule

### rtl/soft_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// soft_timer_bank_unit
// Bank of down-counting timers with once, auto reload and forever modes,
// addressed by index, with due flags read by check and dispatch poll.
//
//   channel   handshake          beat
//   command   start && !busy     cmd  (op, timer_index, mode, ticks)
//   response  done, one cycle    rsp  (due, status)
//
// Register, change, check and poll answer in the cycle after the command beat:
// busy stays low, so beats can follow back to back. A tick walks the timers
// through one shared decrementer, one timer a cycle, with busy high until the
// response. Reset clears all registered bits; counts need no clearing pass.
// The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module soft_timer_bank_unit #(
	parameter int NUM_TIMERS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  stb_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output stb_pkg::rsp_t rsp
);
	import stb_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	stb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (cmd.op),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	stb_datapath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
